>>> rtl/core/afc_pkg.sv
// Shared widths, plane and word types for the AABB frustum cull pipeline.
package afc_pkg;

	localparam int NUM_PLANES = 6;
	localparam int COORD_W    = 16;
	localparam int COEF_W     = 16;
	localparam int FRAC_SHIFT = 14;
	localparam int PLANE_W    = 4 * COEF_W;
	localparam int IDX_W      = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
	localparam int PROD_W     = COEF_W + COORD_W;
	localparam int DSC_W      = COEF_W + FRAC_SHIFT;
	localparam int SUM_W      = ((PROD_W > DSC_W) ? PROD_W : DSC_W) + 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	// register layout: d in the top field, a in the bottom one
	typedef struct packed {
		coef_t d;
		coef_t c;
		coef_t b;
		coef_t a;
	} plane_t;

	// box plus running verdict, handed from cell to cell
	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
		logic   vis;
	} word_t;

	// corner coordinate that maximizes coef * coord along one axis
	function automatic coord_t far_coord(input coef_t k, input coord_t lo, input coord_t hi);
		logic take_hi;
		take_hi = (!k[COEF_W-1]) == (hi >= lo);
		return take_hi ? hi : lo;
	endfunction

endpackage

>>> rtl/core/afc_cell.sv
// One plane cell: holds a plane, tests the box's far corner against it, passes the word on.
module afc_cell import afc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  plane_t cfg_plane,
	input  logic   valid_i,
	input  word_t  word_i,
	output logic   ready_o,
	output logic   valid_o,
	output word_t  word_o,
	input  logic   ready_i
);

	plane_t plane_q;

	logic  valid_s1, valid_s2;
	word_t word_s1, word_s2;
	prod_t px_s1, py_s1, pz_s1;

	logic  rdy_s1, rdy_s2;
	coord_t fx, fy, fz;
	prod_t px, py, pz;
	sum_t  d_sc, sum;
	logic  front;
	word_t word_nx;

	// plane register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_we) begin
			plane_q <= cfg_plane;
		end
	end

	assign rdy_s2  = !valid_s2 || ready_i;
	assign rdy_s1  = !valid_s1 || rdy_s2;
	assign ready_o = rdy_s1;

	// stage 1: far corner select and the three products
	assign fx = far_coord(plane_q.a, word_i.min_x, word_i.max_x);
	assign fy = far_coord(plane_q.b, word_i.min_y, word_i.max_y);
	assign fz = far_coord(plane_q.c, word_i.min_z, word_i.max_z);
	assign px = plane_q.a * fx;
	assign py = plane_q.b * fy;
	assign pz = plane_q.c * fz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && valid_i) begin
			word_s1 <= word_i;
			px_s1   <= px;
			py_s1   <= py;
			pz_s1   <= pz;
		end
	end

	// stage 2: sum with d at product scale, positive means some corner is in front
	assign d_sc  = SUM_W'($signed({plane_q.d, {FRAC_SHIFT{1'b0}}}));
	assign sum   = SUM_W'(px_s1) + SUM_W'(py_s1) + SUM_W'(pz_s1) + d_sc;
	assign front = !sum[SUM_W-1] && (sum != '0);

	always_comb begin
		word_nx     = word_s1;
		word_nx.vis = word_s1.vis && front;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			word_s2 <= word_nx;
		end
	end

	assign valid_o = valid_s2;
	assign word_o  = word_s2;

	// a culled box never comes back to visible
	a_cull_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rdy_s2 && !word_s1.vis) |=> !word_s2.vis)
		else $error("culled box turned visible in cell");

	// a blocked stage 1 word holds until taken
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !rdy_s2) |=> (valid_s1 && $stable(word_s1)))
		else $error("stage 1 word lost while blocked");

	// a blocked stage 2 word holds until taken
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ready_i) |=> (valid_s2 && $stable(word_s2)))
		else $error("stage 2 word lost while blocked");

endmodule

>>> rtl/core/aabb_frustum_cull_top.sv
// Top level of the AABB frustum cull: chain of plane cells and the output register.
// Pipeline: 2*NUM_PLANES+1 register stages; each cell has a multiply stage and a sum stage,
// and the output register comes last.
// Throughput: one box per cycle while the output is not held by out_stall.
// Bubbles collapse: a stage fills whenever it is empty, even with the output blocked.
// Reset (arst_n, async low) clears all valid bits and zeroes every plane,
// so until planes are written every box reports visible = 0.
module aabb_frustum_cull_top import afc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// plane writes
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_idx,
	input  logic [PLANE_W-1:0] cfg_wdata,
	// box words in
	input  logic               in_valid,
	output logic               in_stall,
	input  coord_t             min_x,
	input  coord_t             min_y,
	input  coord_t             min_z,
	input  coord_t             max_x,
	input  coord_t             max_y,
	input  coord_t             max_z,
	// verdict words out
	output logic               out_valid,
	input  logic               out_stall,
	output logic               visible
);

	// chain taps: index i feeds cell i, index NUM_PLANES leaves the last cell
	logic  chain_valid [NUM_PLANES+1];
	word_t chain_word  [NUM_PLANES+1];
	logic  chain_ready [NUM_PLANES+1];

	logic out_valid_q;
	logic visible_q;
	logic rdy_out;

	// the box enters assumed visible; each plane can only clear the flag
	assign chain_valid[0] = in_valid;
	assign chain_word[0]  = '{min_x: min_x, min_y: min_y, min_z: min_z,
	                          max_x: max_x, max_y: max_y, max_z: max_z, vis: 1'b1};
	assign in_stall       = !chain_ready[0];

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
		logic sel;
		assign sel = cfg_we && (cfg_idx == IDX_W'(i));

		afc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg_we    (sel),
			.cfg_plane (plane_t'(cfg_wdata)),
			.valid_i   (chain_valid[i]),
			.word_i    (chain_word[i]),
			.ready_o   (chain_ready[i]),
			.valid_o   (chain_valid[i+1]),
			.word_o    (chain_word[i+1]),
			.ready_i   (chain_ready[i+1])
		);
	end

	// output register parts the chain from the consumer
	assign rdy_out                 = !out_valid_q || !out_stall;
	assign chain_ready[NUM_PLANES] = rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= chain_valid[NUM_PLANES];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && chain_valid[NUM_PLANES]) begin
			visible_q <= chain_word[NUM_PLANES].vis;
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;

	// input only backs up when the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with output free");

	// a word leaving the last cell lands in the output register
	a_tail_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_valid[NUM_PLANES] && rdy_out) |=> out_valid)
		else $error("last cell word dropped");

	// verdict in the output register matches what the last cell handed over
	a_tail_value: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_valid[NUM_PLANES] && rdy_out) |=> (visible == $past(chain_word[NUM_PLANES].vis)))
		else $error("verdict corrupted at output");

endmodule
